// ----- hw/rtl/column_scan_wet_dry_parity_unit_assert.svh -----
// assertion macros used by the port-level checker of the column scan parity unit
`ifndef COLUMN_SCAN_WET_DRY_PARITY_UNIT_ASSERT_SVH
`define COLUMN_SCAN_WET_DRY_PARITY_UNIT_ASSERT_SVH

// same-cycle implication, off while reset is low
`define CSP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define CSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds through reset
`define CSP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/csp_pkg.sv -----
// types, constants and register codes of the column scan parity unit
package csp_pkg;

    // field widths
    localparam int COORD_W   = 32;
    localparam int EDGE_W    = 16;
    localparam int TOL_W     = 31;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SUM_W     = COORD_W + 2;
    localparam int PROD_W    = 2 * DIFF_W;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = TOL_W;
    localparam logic [CFG_IDX_W-1:0] CFG_CROSS_TOL  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_TOL = 1'd1;

    // register reset values, unsigned Q15.16
    localparam logic [TOL_W-1:0] CROSS_TOL_RST  = 31'd655;
    localparam logic [TOL_W-1:0] VERTEX_TOL_RST = 31'd65;

    // edge number that never takes the left vertex
    localparam logic [EDGE_W-1:0] SPECIAL_EDGE = 16'd1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic        [EDGE_W-1:0]  t_edge;
    typedef logic        [TOL_W-1:0]   t_tol;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;

    // geometry of one cell
    typedef struct packed {
        t_coord left_x;
        t_coord left_y;
        t_coord right_x;
        t_coord right_y;
        t_coord center_x;
        t_coord center_y;
        t_edge  edge_index;
    } t_cell;

    // flags that ride along the pipeline
    typedef struct packed {
        logic column_start;
        logic is_cut;
        logic existing_wet;
    } t_side;

    // stage advance strobes
    typedef struct packed {
        logic s2;
        logic s3;
        logic out;
    } t_stage_en;

    // everything the parity stage needs about one cell
    typedef struct packed {
        logic column_start;
        logic is_cut;
        logic existing_wet;
        logic vertex_ok;
        logic straddle;
        logic above;
    } t_par_item;

endpackage

// ----- hw/rtl/csp_edge_test.sv -----
// three-stage edge-above-center test: differences, products, compare
module csp_edge_test (
    input  logic               i_clk,
    input  csp_pkg::t_stage_en i_en,
    input  csp_pkg::t_cell     i_cell,
    input  csp_pkg::t_tol      i_cross_tol,
    output logic               o_straddle,
    output logic               o_above
);

    csp_pkg::t_coord x1, y1, x2, y2, xc, yc;
    logic signed [csp_pkg::SUM_W-1:0] two_c, sum_x;
    logic n_straddle, n_swap, n_gt, n_lt, n_y_up, n_y_dn, n_above_nv;
    csp_pkg::t_diff n_dx, n_dy, n_ex, n_ey;

    // stage 2 registers
    logic r_a_straddle, r_a_above_nv;
    csp_pkg::t_diff r_dx, r_dy, r_ex, r_ey;

    // stage 3 registers
    csp_pkg::t_diff tol_pos, tol_neg;
    csp_pkg::t_prod n_p, n_q, r_p, r_q;
    logic r_b_straddle, r_b_above_nv, r_b_near, r_b_ndx;
    logic above_sl;

    assign x1 = i_cell.left_x;
    assign y1 = i_cell.left_y;
    assign x2 = i_cell.right_x;
    assign y2 = i_cell.right_y;
    assign xc = i_cell.center_x;
    assign yc = i_cell.center_y;

    // side test, differences and the near-vertical midpoint rule
    always_comb begin
        n_straddle = !((x1 < xc && x2 < xc) || (x1 > xc && x2 > xc));
        n_dx = {x2[csp_pkg::COORD_W-1], x2} - {x1[csp_pkg::COORD_W-1], x1};
        n_dy = {y2[csp_pkg::COORD_W-1], y2} - {y1[csp_pkg::COORD_W-1], y1};
        n_ex = {xc[csp_pkg::COORD_W-1], xc} - {x1[csp_pkg::COORD_W-1], x1};
        n_ey = {yc[csp_pkg::COORD_W-1], yc} - {y1[csp_pkg::COORD_W-1], y1};
        // center past the midpoint of the ordered endpoints
        two_c = {xc[csp_pkg::COORD_W-1], xc, 1'b0};
        sum_x = {{2{x1[csp_pkg::COORD_W-1]}}, x1} + {{2{x2[csp_pkg::COORD_W-1]}}, x2};
        n_gt = two_c > sum_x;
        n_lt = two_c < sum_x;
        n_swap = x2 < x1;
        n_y_up = n_swap ? (y2 < y1) : (y1 < y2);
        n_y_dn = n_swap ? (y2 > y1) : (y1 > y2);
        n_above_nv = (n_gt && n_y_up) || (n_lt && n_y_dn);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_a_straddle <= n_straddle;
            r_a_above_nv <= n_above_nv;
            r_dx <= n_dx;
            r_dy <= n_dy;
            r_ex <= n_ex;
            r_ey <= n_ey;
        end
    end

    // cross products and the tolerance window on the x spread
    always_comb begin
        tol_pos = {2'b00, i_cross_tol};
        tol_neg = -tol_pos;
        n_p = r_dy * r_ex;
        n_q = r_ey * r_dx;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_p <= n_p;
            r_q <= n_q;
            r_b_straddle <= r_a_straddle;
            r_b_above_nv <= r_a_above_nv;
            r_b_near <= (r_dx < tol_pos) && (r_dx > tol_neg);
            r_b_ndx <= r_dx[csp_pkg::DIFF_W-1];
        end
    end

    // line through the endpoints against the center height
    assign above_sl   = r_b_ndx ? (r_p < r_q) : (r_p > r_q);
    assign o_straddle = r_b_straddle;
    assign o_above    = r_b_near ? r_b_above_nv : above_sl;

endmodule

// ----- hw/rtl/csp_vertex_check.sv -----
// shared-vertex test against the previous cell of the stream
module csp_vertex_check (
    input  logic               i_clk,
    input  csp_pkg::t_stage_en i_en,
    input  csp_pkg::t_cell     i_cell,
    input  csp_pkg::t_tol      i_vertex_tol,
    output logic               o_vertex_ok
);

    csp_pkg::t_coord r_prv_lx, r_prv_rx, r_prv_cx;
    csp_pkg::t_edge  r_prv_edge;
    csp_pkg::t_diff  d_l, d_r, vt_pos, vt_neg;
    logic near_l, near_r, side_l, side_r, take_left;

    // previous cell as it left the input stage
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_prv_lx   <= i_cell.left_x;
            r_prv_rx   <= i_cell.right_x;
            r_prv_cx   <= i_cell.center_x;
            r_prv_edge <= i_cell.edge_index;
        end
    end

    // both vertex choices evaluated in parallel, then selected
    always_comb begin
        vt_pos = {2'b00, i_vertex_tol};
        vt_neg = -vt_pos;
        d_l = {r_prv_lx[csp_pkg::COORD_W-1], r_prv_lx}
            - {r_prv_cx[csp_pkg::COORD_W-1], r_prv_cx};
        d_r = {r_prv_rx[csp_pkg::COORD_W-1], r_prv_rx}
            - {r_prv_cx[csp_pkg::COORD_W-1], r_prv_cx};
        near_l = (d_l < vt_pos) && (d_l > vt_neg);
        near_r = (d_r < vt_pos) && (d_r > vt_neg);
        side_l = (r_prv_rx > r_prv_cx && i_cell.left_x > r_prv_cx)
              || (r_prv_rx < r_prv_cx && i_cell.left_x < r_prv_cx);
        side_r = (r_prv_lx > r_prv_cx && i_cell.right_x > r_prv_cx)
              || (r_prv_lx < r_prv_cx && i_cell.right_x < r_prv_cx);
        take_left = (r_prv_edge > i_cell.edge_index)
                 && (i_cell.edge_index != csp_pkg::SPECIAL_EDGE);
        o_vertex_ok = take_left ? (near_l && side_l) : (near_r && side_r);
    end

endmodule

// ----- hw/rtl/csp_parity.sv -----
// running wet/dry parity and the result register
module csp_parity (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  csp_pkg::t_stage_en i_en,
    input  csp_pkg::t_par_item i_item,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic               o_cell_wet
);

    logic r_running, r_prev_wet, r_prev_cut, r_prev_above, r_out_valid, r_wet;
    logic n_running, n_wet, crossing;

    // parity update for the cell leaving the last stage
    always_comb begin
        crossing = r_prev_cut && r_prev_above;
        n_running = r_running;
        n_wet = r_running;
        if (i_item.column_start) begin
            n_running = 1'b0;
            n_wet = i_item.existing_wet;
        end else begin
            if (crossing) begin
                if (i_item.is_cut && i_item.vertex_ok) begin
                    n_running = r_prev_wet;
                end else begin
                    n_running = !r_running;
                end
            end else if (i_item.is_cut && i_item.straddle && !i_item.above) begin
                n_running = !r_running;
            end
            n_wet = n_running;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running    <= 1'b0;
            r_prev_wet   <= 1'b0;
            r_prev_cut   <= 1'b0;
            r_prev_above <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_en.out) begin
                r_running    <= n_running;
                r_prev_wet   <= n_wet;
                r_prev_cut   <= i_item.is_cut;
                r_prev_above <= i_item.straddle && i_item.above;
                r_out_valid  <= !i_item.column_start;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_en.out) begin
            r_wet <= n_wet;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cell_wet  = r_wet;

endmodule

// ----- hw/rtl/column_scan_wet_dry_parity_unit.sv -----
// top level of the column scan wet/dry parity unit
//
// Cells enter on the input channel (i_in_valid / o_in_stall) bottom to top,
// column by column; i_column_start marks the first cell of a column. Every
// other cell yields one item on the output channel (o_out_valid / i_out_stall)
// carrying o_cell_wet. A column start yields no item; it clears the parity
// and seeds the previous type from i_existing_wet.
// On the way to o_out_valid, the input register feeds a difference stage,
// a multiply stage for the 33x33 cross products, and the compare plus
// parity update into the result register. Throughput is one item per
// cycle while the receiver does not stall; the one-bit parity loop closes
// within the last stage.
// When the receiver stalls, the result register holds and the stages behind
// it keep filling until all four hold an item; only then is o_in_stall
// raised. Tolerances must be written through i_cfg_we / i_cfg_idx /
// i_cfg_data only while the unit is idle; the unit does not enforce this.
// Synchronous reset empties the pipeline, sets the parity and previous cell
// to dry and uncut, and loads the default tolerances.
module column_scan_wet_dry_parity_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [csp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [csp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // cell items
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_column_start,
    input  logic                             i_is_cut,
    input  logic signed [csp_pkg::COORD_W-1:0] i_left_x,
    input  logic signed [csp_pkg::COORD_W-1:0] i_left_y,
    input  logic signed [csp_pkg::COORD_W-1:0] i_right_x,
    input  logic signed [csp_pkg::COORD_W-1:0] i_right_y,
    input  logic signed [csp_pkg::COORD_W-1:0] i_center_x,
    input  logic signed [csp_pkg::COORD_W-1:0] i_center_y,
    input  logic [csp_pkg::EDGE_W-1:0]       i_edge_index,
    input  logic                             i_existing_wet,
    // result items
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_cell_wet
);

    csp_pkg::t_tol      r_cross_tol, r_vertex_tol;
    csp_pkg::t_cell     r_cell;
    csp_pkg::t_side     r_s1_side, r_s2_side, r_s3_side;
    logic               r_v1, r_v2, r_v3, r_s2_vtx, r_s3_vtx;
    logic               accept, vertex_ok, straddle, above, out_valid;
    csp_pkg::t_stage_en en;
    csp_pkg::t_par_item par_item;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cross_tol  <= csp_pkg::CROSS_TOL_RST;
            r_vertex_tol <= csp_pkg::VERTEX_TOL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                csp_pkg::CFG_CROSS_TOL: begin
                    r_cross_tol <= i_cfg_data;
                end
                csp_pkg::CFG_VERTEX_TOL: begin
                    r_vertex_tol <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // stage advance: a stage moves when the next one is empty or moving
    always_comb begin
        en.out = r_v3 && (!out_valid || !i_out_stall);
        en.s3  = r_v2 && (!r_v3 || en.out);
        en.s2  = r_v1 && (!r_v2 || en.s3);
        accept = i_in_valid && (!r_v1 || en.s2);
    end

    assign o_in_stall = r_v1 && !(!r_v2 || en.s3);

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (accept) begin
                r_v1 <= 1'b1;
            end else if (en.s2) begin
                r_v1 <= 1'b0;
            end
            if (en.s2) begin
                r_v2 <= 1'b1;
            end else if (en.s3) begin
                r_v2 <= 1'b0;
            end
            if (en.s3) begin
                r_v3 <= 1'b1;
            end else if (en.out) begin
                r_v3 <= 1'b0;
            end
        end
    end

    // input register and side flags along the stages
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cell.left_x     <= i_left_x;
            r_cell.left_y     <= i_left_y;
            r_cell.right_x    <= i_right_x;
            r_cell.right_y    <= i_right_y;
            r_cell.center_x   <= i_center_x;
            r_cell.center_y   <= i_center_y;
            r_cell.edge_index <= i_edge_index;
            r_s1_side.column_start <= i_column_start;
            r_s1_side.is_cut       <= i_is_cut;
            r_s1_side.existing_wet <= i_existing_wet;
        end
        if (en.s2) begin
            r_s2_side <= r_s1_side;
            r_s2_vtx  <= vertex_ok;
        end
        if (en.s3) begin
            r_s3_side <= r_s2_side;
            r_s3_vtx  <= r_s2_vtx;
        end
    end

    csp_edge_test u_edge_test (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_cell      (r_cell),
        .i_cross_tol (r_cross_tol),
        .o_straddle  (straddle),
        .o_above     (above)
    );

    csp_vertex_check u_vertex_check (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_cell       (r_cell),
        .i_vertex_tol (r_vertex_tol),
        .o_vertex_ok  (vertex_ok)
    );

    // gather the last stage for the parity update
    always_comb begin
        par_item.column_start = r_s3_side.column_start;
        par_item.is_cut       = r_s3_side.is_cut;
        par_item.existing_wet = r_s3_side.existing_wet;
        par_item.vertex_ok    = r_s3_vtx;
        par_item.straddle     = straddle;
        par_item.above        = above;
    end

    csp_parity u_parity (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_item      (par_item),
        .i_out_stall (i_out_stall),
        .o_out_valid (out_valid),
        .o_cell_wet  (o_cell_wet)
    );

    assign o_out_valid = out_valid;

endmodule

// ----- hw/rtl/csp_checker.sv -----
// port-level checker of the column scan parity unit, bound to the top level
`include "column_scan_wet_dry_parity_unit_assert.svh"

module csp_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_stall,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  logic i_cell_wet
);

    // reset empties the pipeline and opens the input side
    `CSP_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !i_out_valid && !i_in_stall, "output valid or input stalled after reset")

    // input is held off only when every stage is full behind a stalled result
    `CSP_ASSERT_SAME(a_stall_only_when_full, i_clk, i_rst_n, i_in_stall, i_out_valid && i_out_stall, "input stalled without a stalled result")

    // a stalled result keeps its value
    `CSP_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_cell_wet), "stalled result dropped or changed")

endmodule

bind column_scan_wet_dry_parity_unit csp_checker u_csp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_cell_wet  (o_cell_wet)
);
